FILE: rtl/gow_pkg.sv
// gow_pkg: shared constants, types and fixed-point helpers for the weight update block
// depends on nothing; every other file but gow_ram imports it
package gow_pkg;

   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS  = 24;
   localparam int DEPTH      = 1024;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int INDEX_BITS = 10;
   localparam int CFG_BITS   = 25;
   localparam int EPS_BITS   = 16;
   localparam int WIDE_BITS  = 56;
   localparam int DEN_BITS   = 29;
   localparam int ROOT_BITS  = 28;

   localparam logic [CFG_BITS-1:0] ONE_Q   = CFG_BITS'(1) << FRAC_BITS;
   localparam logic [CFG_BITS-1:0] POW_MAX = '1;

   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   localparam logic [2:0] MODE_SGD     = 3'd0;
   localparam logic [2:0] MODE_RMSPROP = 3'd1;
   localparam logic [2:0] MODE_ADAGRAD = 3'd2;
   localparam logic [2:0] MODE_ADAM    = 3'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BADMODE = 2'd1;
   localparam logic [1:0] STATUS_SAT     = 2'd2;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_GRADIENT = 1'b1;

   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_LR        = 3'd1;
   localparam logic [2:0] CSR_MOMENTUM  = 3'd2;
   localparam logic [2:0] CSR_BETA_ONE  = 3'd3;
   localparam logic [2:0] CSR_BETA_TWO  = 3'd4;
   localparam logic [2:0] CSR_EPSILON   = 3'd5;
   localparam logic [2:0] CSR_TRAINABLE = 3'd6;

   typedef struct packed {
      logic                         sat;
      logic signed [VALUE_BITS-1:0] val;
   } sat_type;

   typedef struct packed {
      logic                         neg;
      logic [63:0]                  mag;
      logic signed [VALUE_BITS-1:0] q;
      logic                         qsat;
   } mul_res_type;

   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [WIDE_BITS-1:0] num;
      logic                 den_neg;
      logic [DEN_BITS-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                         busy;
      logic                         done;
      logic signed [VALUE_BITS-1:0] val;
      logic                         sat;
   } div_rsp_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } sqrt_rsp_type;

   // sign and magnitude back to a saturated signed value
   function automatic sat_type from_mag(input logic neg, input logic [WIDE_BITS-1:0] mag);
      sat_type r;
      r.sat = 1'b0;
      r.val = '0;
      if (!neg) begin
         if (mag > WIDE_BITS'(VAL_MAX)) begin
            r.sat = 1'b1;
            r.val = VAL_MAX;
         end else begin
            r.val = mag[VALUE_BITS-1:0];
         end
      end else begin
         if (mag > (WIDE_BITS'(VAL_MAX) + WIDE_BITS'(1))) begin
            r.sat = 1'b1;
            r.val = VAL_MIN;
         end else begin
            r.val = -mag[VALUE_BITS-1:0];
         end
      end
      return r;
   endfunction

   function automatic sat_type clamp_sum(input logic signed [VALUE_BITS+1:0] x);
      sat_type r;
      r.sat = 1'b0;
      r.val = x[VALUE_BITS-1:0];
      if (x > (VALUE_BITS+2)'(VAL_MAX)) begin
         r.sat = 1'b1;
         r.val = VAL_MAX;
      end else if (x < (VALUE_BITS+2)'(VAL_MIN)) begin
         r.sat = 1'b1;
         r.val = VAL_MIN;
      end
      return r;
   endfunction

   function automatic logic [VALUE_BITS-1:0] mag_of(input logic signed [VALUE_BITS-1:0] x);
      return x[VALUE_BITS-1] ? VALUE_BITS'(-x) : VALUE_BITS'(x);
   endfunction

endpackage

FILE: rtl/gow_req_if.sv
// gow_req_if: request channel, one word per weight load or gradient
// depends on gow_pkg
interface gow_req_if import gow_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [INDEX_BITS-1:0]        index;
   logic signed [VALUE_BITS-1:0] value;
   logic                         last;

   modport source (output valid, opcode, index, value, last, input ready);
   modport sink   (input valid, opcode, index, value, last, output ready);
endinterface

FILE: rtl/gow_rsp_if.sv
// gow_rsp_if: response channel, one word per request with the new weight
// depends on gow_pkg
interface gow_rsp_if import gow_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [INDEX_BITS-1:0]        out_index;
   logic signed [VALUE_BITS-1:0] new_weight;
   logic [1:0]                   status;

   modport source (output valid, out_index, new_weight, status, input ready);
   modport sink   (input valid, out_index, new_weight, status, output ready);
endinterface

FILE: rtl/gradient_optimizer_weight_update.sv
// gradient_optimizer_weight_update: top level, sequencer around weight and state memories
// depends on gow_pkg, gow_req_if, gow_rsp_if, gow_ram, gow_mulq, gow_div, gow_sqrt
//
//   port      dir   kind            carries
//   req_bus   in    valid/ready     opcode, index, value, last
//   rsp_bus   out   valid/ready     out_index, new_weight, status
//   csr_*     in    write enable    index (3 bits), data (25 bits)
//
// one word at a time; the sequencer reads the weight and {moment, velocity} entries, runs
// the update on one shared multiplier, a bit-serial divider and root unit, writes back
// adam runs three divisions and a root (a zero root or divisor is shorter) and, on the
// last word, advances the step powers
// synchronous active-high reset returns the sequencer, config registers and step powers to defaults, not memories
// a waiting response is held in its own register; the next word is taken meanwhile
module gradient_optimizer_weight_update import gow_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   gow_req_if.sink             req_bus,
   gow_rsp_if.source           rsp_bus,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);
   typedef enum logic [4:0] {
      ST_IDLE, ST_READ,
      ST_SG_A, ST_SG_B, ST_SG_C, ST_SG_D,
      ST_RM_A, ST_RM_B, ST_RM_C, ST_RM_D,
      ST_AD_A, ST_AD_B,
      ST_AM_A, ST_AM_B, ST_AM_C, ST_AM_D, ST_AM_E, ST_AM_F,
      ST_BF1_WAIT, ST_BF2_GO, ST_BF2_WAIT,
      ST_SQ_GO, ST_SQ_WAIT,
      ST_RT_MUL, ST_RT_GO, ST_RT_WAIT,
      ST_PW_A, ST_PW_B, ST_PW_C,
      ST_WRITE, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]          mode_ff;
   logic [CFG_BITS-1:0] lr_ff, mom_ff, b1_ff, b2_ff, p1_ff, p2_ff, p1_in, p2_in;
   logic [EPS_BITS-1:0] eps_ff;
   logic                train_ff;

   logic                         op_ff, op_in, last_ff, last_in;
   logic [ADDR_BITS-1:0]         idx_ff, idx_in;
   logic signed [VALUE_BITS-1:0] g_ff, g_in, w_ff, w_in, v_ff, v_in, m_ff, m_in;
   logic signed [VALUE_BITS-1:0] t1_ff, t1_in, num_ff, num_in, rad_ff, rad_in;
   logic [DEN_BITS-1:0]          d_ff, d_in;
   logic                         sat_ff, sat_in, bad_ff, bad_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [VALUE_BITS-1:0] rsp_weight_ff, rsp_weight_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic                    wr_en;
   logic [VALUE_BITS-1:0]   w_rdata;
   logic [2*VALUE_BITS-1:0] s_rdata;

   logic signed [32:0] mul_a, mul_b;
   mul_res_type        mul_res;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               sq_start;
   sqrt_rsp_type       sq_rsp;

   logic signed [32:0] lr_op, mom_op, b1_op, b2_op, nb1_op, nb2_op;
   logic signed [32:0] g_op, v_op, m_op, q_op, p1_op, p2_op;
   logic signed [25:0] bden1, bden2;
   logic [25:0]        bmag1, bmag2;
   sat_type            cl;
   logic [39:0]        pw_raw;
   logic [CFG_BITS-1:0] pw_sat;

   localparam logic signed [32:0] ONE_OP = 33'(ONE_Q);

   assign lr_op  = $signed({8'd0, lr_ff});
   assign mom_op = $signed({8'd0, mom_ff});
   assign b1_op  = $signed({8'd0, b1_ff});
   assign b2_op  = $signed({8'd0, b2_ff});
   assign p1_op  = $signed({8'd0, p1_ff});
   assign p2_op  = $signed({8'd0, p2_ff});
   assign nb1_op = ONE_OP - b1_op;
   assign nb2_op = ONE_OP - b2_op;
   assign g_op   = 33'(g_ff);
   assign v_op   = 33'(v_ff);
   assign m_op   = 33'(m_ff);
   assign q_op   = 33'(mul_res.q);

   // bias correction divisor 1 - power, may go negative
   assign bden1 = $signed({1'b0, ONE_Q}) - $signed({1'b0, p1_ff});
   assign bden2 = $signed({1'b0, ONE_Q}) - $signed({1'b0, p2_ff});
   assign bmag1 = bden1[25] ? 26'(-bden1) : 26'(bden1);
   assign bmag2 = bden2[25] ? 26'(-bden2) : 26'(bden2);

   assign pw_raw = mul_res.mag[63:FRAC_BITS];
   assign pw_sat = (pw_raw > 40'(POW_MAX)) ? POW_MAX : pw_raw[CFG_BITS-1:0];

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = state_ff == ST_IDLE;
   assign wr_en         = state_ff == ST_WRITE;

   gow_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (w_ff),
      .rd_addr (req_bus.index[ADDR_BITS-1:0]),
      .rd_data (w_rdata)
   );

   gow_ram #(.WIDTH(2*VALUE_BITS), .DEPTH(DEPTH)) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data ({m_ff, v_ff}),
      .rd_addr (req_bus.index[ADDR_BITS-1:0]),
      .rd_data (s_rdata)
   );

   gow_mulq u_mulq (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .res   (mul_res)
   );

   gow_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gow_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (rad_ff),
      .rsp      (sq_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      g_in          = g_ff;
      w_in          = w_ff;
      v_in          = v_ff;
      m_in          = m_ff;
      t1_in         = t1_ff;
      num_in        = num_ff;
      rad_in        = rad_ff;
      d_in          = d_ff;
      sat_in        = sat_ff;
      bad_in        = bad_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_status_in = rsp_status_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;
      sq_start      = 1'b0;
      cl            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_bus.opcode;
               last_in  = req_bus.last;
               idx_in   = req_bus.index[ADDR_BITS-1:0];
               g_in     = req_bus.value;
               sat_in   = 1'b0;
               bad_in   = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            w_in = w_rdata;
            v_in = s_rdata[VALUE_BITS-1:0];
            m_in = s_rdata[2*VALUE_BITS-1:VALUE_BITS];
            if (op_ff == OP_LOAD) begin
               w_in     = g_ff;
               v_in     = '0;
               m_in     = '0;
               state_in = ST_WRITE;
            end else if (!train_ff) begin
               state_in = ST_FINISH;
            end else begin
               case (mode_ff)
                  MODE_SGD:     state_in = (mom_ff != '0) ? ST_SG_A : ST_SG_B;
                  MODE_RMSPROP: state_in = ST_RM_A;
                  MODE_ADAGRAD: state_in = ST_AD_A;
                  MODE_ADAM:    state_in = ST_AM_A;
                  default: begin
                     bad_in   = 1'b1;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SG_A: begin
            mul_a    = mom_op;
            mul_b    = v_op;
            state_in = ST_SG_B;
         end
         ST_SG_B: begin
            if (mom_ff != '0) begin
               t1_in  = mul_res.q;
               sat_in = sat_ff | mul_res.qsat;
            end
            mul_a    = lr_op;
            mul_b    = g_op;
            state_in = ST_SG_C;
         end
         ST_SG_C: begin
            if (mom_ff != '0) begin
               cl       = clamp_sum(34'(t1_ff) - 34'(mul_res.q));
               v_in     = cl.val;
               state_in = ST_SG_D;
            end else begin
               cl       = clamp_sum(34'(w_ff) - 34'(mul_res.q));
               w_in     = cl.val;
               state_in = ST_WRITE;
            end
            sat_in = sat_ff | mul_res.qsat | cl.sat;
         end
         ST_SG_D: begin
            cl       = clamp_sum(34'(w_ff) + 34'(v_ff));
            w_in     = cl.val;
            sat_in   = sat_ff | cl.sat;
            state_in = ST_WRITE;
         end
         ST_RM_A: begin
            mul_a    = b1_op;
            mul_b    = v_op;
            state_in = ST_RM_B;
         end
         ST_RM_B: begin
            t1_in    = mul_res.q;
            sat_in   = sat_ff | mul_res.qsat;
            mul_a    = nb1_op;
            mul_b    = g_op;
            state_in = ST_RM_C;
         end
         ST_RM_C: begin
            sat_in   = sat_ff | mul_res.qsat;
            mul_a    = q_op;
            mul_b    = g_op;
            state_in = ST_RM_D;
         end
         ST_RM_D: begin
            cl       = clamp_sum(34'(t1_ff) + 34'(mul_res.q));
            v_in     = cl.val;
            rad_in   = cl.val;
            num_in   = g_ff;
            sat_in   = sat_ff | mul_res.qsat | cl.sat;
            state_in = ST_SQ_GO;
         end
         ST_AD_A: begin
            mul_a    = g_op;
            mul_b    = g_op;
            state_in = ST_AD_B;
         end
         ST_AD_B: begin
            cl       = clamp_sum(34'(v_ff) + 34'(mul_res.q));
            v_in     = cl.val;
            rad_in   = cl.val;
            num_in   = g_ff;
            sat_in   = sat_ff | mul_res.qsat | cl.sat;
            state_in = ST_SQ_GO;
         end
         ST_AM_A: begin
            mul_a    = b1_op;
            mul_b    = m_op;
            state_in = ST_AM_B;
         end
         ST_AM_B: begin
            t1_in    = mul_res.q;
            sat_in   = sat_ff | mul_res.qsat;
            mul_a    = nb1_op;
            mul_b    = g_op;
            state_in = ST_AM_C;
         end
         ST_AM_C: begin
            cl       = clamp_sum(34'(t1_ff) + 34'(mul_res.q));
            m_in     = cl.val;
            sat_in   = sat_ff | mul_res.qsat | cl.sat;
            mul_a    = b2_op;
            mul_b    = v_op;
            state_in = ST_AM_D;
         end
         ST_AM_D: begin
            t1_in    = mul_res.q;
            sat_in   = sat_ff | mul_res.qsat;
            mul_a    = nb2_op;
            mul_b    = g_op;
            state_in = ST_AM_E;
         end
         ST_AM_E: begin
            sat_in   = sat_ff | mul_res.qsat;
            mul_a    = q_op;
            mul_b    = g_op;
            state_in = ST_AM_F;
         end
         ST_AM_F: begin
            cl       = clamp_sum(34'(t1_ff) + 34'(mul_res.q));
            v_in     = cl.val;
            sat_in   = sat_ff | mul_res.qsat | cl.sat;
            // first moment bias correction
            div_req.start   = 1'b1;
            div_req.neg     = m_ff[VALUE_BITS-1];
            div_req.num     = {mag_of(m_ff), {FRAC_BITS{1'b0}}};
            div_req.den_neg = bden1[25];
            div_req.den     = DEN_BITS'(bmag1);
            state_in        = ST_BF1_WAIT;
         end
         ST_BF1_WAIT: begin
            if (div_rsp.done) begin
               num_in   = div_rsp.val;
               sat_in   = sat_ff | div_rsp.sat;
               state_in = ST_BF2_GO;
            end
         end
         ST_BF2_GO: begin
            div_req.start   = 1'b1;
            div_req.neg     = v_ff[VALUE_BITS-1];
            div_req.num     = {mag_of(v_ff), {FRAC_BITS{1'b0}}};
            div_req.den_neg = bden2[25];
            div_req.den     = DEN_BITS'(bmag2);
            state_in        = ST_BF2_WAIT;
         end
         ST_BF2_WAIT: begin
            if (div_rsp.done) begin
               rad_in   = div_rsp.val;
               sat_in   = sat_ff | div_rsp.sat;
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            sq_start = 1'b1;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (sq_rsp.done) begin
               d_in     = {1'b0, sq_rsp.root} + DEN_BITS'(eps_ff);
               state_in = ST_RT_MUL;
            end
         end
         ST_RT_MUL: begin
            mul_a    = lr_op;
            mul_b    = 33'(num_ff);
            state_in = ST_RT_GO;
         end
         ST_RT_GO: begin
            div_req.start   = 1'b1;
            div_req.neg     = mul_res.neg;
            div_req.num     = mul_res.mag[WIDE_BITS-1:0];
            div_req.den_neg = 1'b0;
            div_req.den     = d_ff;
            state_in        = ST_RT_WAIT;
         end
         ST_RT_WAIT: begin
            if (div_rsp.done) begin
               cl     = clamp_sum(34'(w_ff) - 34'(div_rsp.val));
               w_in   = cl.val;
               sat_in = sat_ff | div_rsp.sat | cl.sat;
               state_in = (mode_ff == MODE_ADAM && last_ff) ? ST_PW_A : ST_WRITE;
            end
         end
         ST_PW_A: begin
            mul_a    = p1_op;
            mul_b    = b1_op;
            state_in = ST_PW_B;
         end
         ST_PW_B: begin
            p1_in    = pw_sat;
            mul_a    = p2_op;
            mul_b    = b2_op;
            state_in = ST_PW_C;
         end
         ST_PW_C: begin
            p2_in    = pw_sat;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = INDEX_BITS'(idx_ff);
               rsp_weight_in = w_ff;
               rsp_status_in = bad_ff ? STATUS_BADMODE : (sat_ff ? STATUS_SAT : STATUS_OK);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a beta write restarts its power sequence
      if (csr_we && csr_index == CSR_BETA_ONE) begin
         p1_in = csr_wdata;
      end
      if (csr_we && csr_index == CSR_BETA_TWO) begin
         p2_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_SGD;
         lr_ff        <= 25'd167772;
         mom_ff       <= '0;
         b1_ff        <= 25'd15099494;
         b2_ff        <= 25'd16760438;
         eps_ff       <= 16'd2;
         train_ff     <= 1'b1;
         p1_ff        <= 25'd15099494;
         p2_ff        <= 25'd16760438;
         sat_ff       <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         sat_ff       <= sat_in;
         bad_ff       <= bad_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:      mode_ff  <= csr_wdata[2:0];
               CSR_LR:        lr_ff    <= csr_wdata;
               CSR_MOMENTUM:  mom_ff   <= csr_wdata;
               CSR_BETA_ONE:  b1_ff    <= csr_wdata;
               CSR_BETA_TWO:  b2_ff    <= csr_wdata;
               CSR_EPSILON:   eps_ff   <= csr_wdata[EPS_BITS-1:0];
               CSR_TRAINABLE: train_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      g_ff          <= g_in;
      w_ff          <= w_in;
      v_ff          <= v_in;
      m_ff          <= m_in;
      t1_ff         <= t1_in;
      num_ff        <= num_in;
      rad_ff        <= rad_in;
      d_ff          <= d_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_index  = rsp_index_ff;
   assign rsp_bus.new_weight = rsp_weight_ff;
   assign rsp_bus.status     = rsp_status_ff;

`ifndef ASSERT_OFF
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("accepted word did not go to memory read");

   a_sqrt_done_waited: assert property (@(posedge clock) disable iff (reset)
      sq_rsp.done |-> state_ff == ST_SQ_WAIT)
      else $error("root finished with nobody waiting");

   a_power_source: assert property (@(posedge clock) disable iff (reset)
      !$stable(p1_ff) |-> $past(reset) || $past(state_ff == ST_PW_B)
                          || $past(csr_we && csr_index == CSR_BETA_ONE))
      else $error("beta one power changed without cause");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_bus.ready) |=> state_ff == ST_FINISH)
      else $error("response register overwritten while pending");
`endif
endmodule

FILE: rtl/gow_ram.sv
// gow_ram: single write port, single read port memory with registered read data
// standalone, no package needed
module gow_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/gow_mulq.sv
// gow_mulq: shared signed multiplier, registered; full magnitude product and q.24 result
// depends on gow_pkg
module gow_mulq import gow_pkg::*; (
   input  logic              clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output mul_res_type       res
);
   logic [32:0] mag_a, mag_b;
   logic [63:0] prod;
   logic        neg;
   sat_type     qv;

   always_comb begin
      mag_a = op_a[32] ? 33'(-op_a) : 33'(op_a);
      mag_b = op_b[32] ? 33'(-op_b) : 33'(op_b);
      prod  = mag_a[31:0] * mag_b[31:0];
      neg   = op_a[32] ^ op_b[32];
      qv    = from_mag(neg, WIDE_BITS'(prod[63:FRAC_BITS]));
   end

   always_ff @(posedge clock) begin
      res.neg  <= neg;
      res.mag  <= prod;
      res.q    <= qv.val;
      res.qsat <= qv.sat;
   end
endmodule

FILE: rtl/gow_div.sv
// gow_div: restoring divider, one quotient bit per cycle, saturating signed result
// depends on gow_pkg
module gow_div import gow_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic                 busy_ff, done_ff, neg_ff, sat_ff;
   logic [5:0]           cnt_ff;
   logic [WIDE_BITS-1:0] num_ff, quo_ff;
   logic [DEN_BITS-1:0]  rem_ff, den_ff;
   logic signed [VALUE_BITS-1:0] val_ff;

   logic [DEN_BITS:0]    part;
   logic                 ge;
   logic [DEN_BITS:0]    rem_in;
   logic [WIDE_BITS-1:0] quo_in;
   sat_type              fm;

   always_comb begin
      part   = {rem_ff, num_ff[WIDE_BITS-1]};
      ge     = part >= {1'b0, den_ff};
      rem_in = ge ? part - {1'b0, den_ff} : part;
      quo_in = {quo_ff[WIDE_BITS-2:0], ge};
      fm     = from_mag(neg_ff, quo_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            if (req.den == '0) begin
               // zero divisor: zero stays zero, anything else pins toward its sign
               done_ff <= 1'b1;
               sat_ff  <= req.num != '0;
               val_ff  <= (req.num == '0) ? '0 : (req.neg ? VAL_MIN : VAL_MAX);
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= 6'(WIDE_BITS - 1);
               num_ff  <= req.num;
               rem_ff  <= '0;
               quo_ff  <= '0;
               den_ff  <= req.den;
               neg_ff  <= req.neg ^ req.den_neg;
            end
         end else if (busy_ff) begin
            num_ff <= {num_ff[WIDE_BITS-2:0], 1'b0};
            rem_ff <= rem_in[DEN_BITS-1:0];
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               val_ff  <= fm.val;
               sat_ff  <= fm.sat;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.val  = val_ff;
   assign rsp.sat  = sat_ff;
endmodule

FILE: rtl/gow_sqrt.sv
// gow_sqrt: digit-by-digit square root of a q.24 value, one root bit per cycle
// depends on gow_pkg
module gow_sqrt import gow_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [VALUE_BITS-1:0] radicand,
   output sqrt_rsp_type                 rsp
);
   logic                 busy_ff, done_ff;
   logic [4:0]           cnt_ff;
   logic [WIDE_BITS-1:0] rad_ff;
   logic [ROOT_BITS+1:0] rem_ff;
   logic [ROOT_BITS-1:0] root_ff, out_ff;

   logic [ROOT_BITS+3:0] cat;
   logic [ROOT_BITS+3:0] trial;
   logic                 ge;
   logic [ROOT_BITS+3:0] rem_in;
   logic [ROOT_BITS-1:0] root_in;

   always_comb begin
      cat     = {rem_ff, rad_ff[WIDE_BITS-1:WIDE_BITS-2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = cat >= trial;
      rem_in  = ge ? cat - trial : cat;
      root_in = {root_ff[ROOT_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (radicand[VALUE_BITS-1] || radicand == '0) begin
               // nonpositive radicand gives zero
               done_ff <= 1'b1;
               out_ff  <= '0;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= 5'(ROOT_BITS - 1);
               rad_ff  <= {1'b0, radicand[VALUE_BITS-2:0], {FRAC_BITS{1'b0}}};
               rem_ff  <= '0;
               root_ff <= '0;
            end
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[WIDE_BITS-3:0], 2'b00};
            rem_ff  <= rem_in[ROOT_BITS+1:0];
            root_ff <= root_in;
            cnt_ff  <= cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               out_ff  <= root_in;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = out_ff;
endmodule
